// File: design/srdf_pkg.sv
//------------------------------------------------------------------------------
// srdf_pkg
// Shared types and constants for the shadow register file with dirty flush.
//------------------------------------------------------------------------------
`default_nettype none

package srdf_pkg;

	localparam int IDX_W   = 3;
	localparam int WORD_W  = 32;
	localparam int BIT_W   = 6;
	localparam int MODE_W  = 2;
	localparam int TOP_BIT = 31;

	// word whose dirty state forces word 0 out on a flush
	localparam int FORCE_WORD = 4;

	localparam logic [MODE_W-1:0] MODE_FIELD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ALL   = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  reg_index;
		logic [BIT_W-1:0]  bit_high;
		logic [BIT_W-1:0]  bit_low;
		logic [WORD_W-1:0] field_value;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  word_index;
		logic [WORD_W-1:0] word_value;
		logic              last_word;
	} out_item_t;

	// decoded field write handed from the decoder to the sequencer
	typedef struct packed {
		logic              ok;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] ins;
	} field_cmd_t;

endpackage

`default_nettype wire

// File: design/srdf_chan_if.sv
//------------------------------------------------------------------------------
// srdf_chan_if
// Valid/ready channel carrying one payload per transaction.
//------------------------------------------------------------------------------
`default_nettype none

interface srdf_chan_if #(parameter type payload_t = logic);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: design/srdf_ram.sv
//------------------------------------------------------------------------------
// srdf_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module srdf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/srdf_field.sv
//------------------------------------------------------------------------------
// srdf_field
// Decodes a field write: orders the bounds, checks them, builds mask and value.
//------------------------------------------------------------------------------
`default_nettype none

module srdf_field #(
	parameter int NUM_WORDS       = 7,
	parameter int ADDR_FIELD_BITS = 3
) (
	input  wire srdf_pkg::in_item_t   item,
	output srdf_pkg::field_cmd_t      cmd
);

	import srdf_pkg::*;

	logic [BIT_W-1:0] hi;
	logic [BIT_W-1:0] lo;
	logic [4:0]       hi5;
	logic [4:0]       lo5;
	logic [WORD_W-1:0] mask;

	always_comb begin
		if (item.bit_low > item.bit_high) begin
			hi = item.bit_low;
			lo = item.bit_high;
		end else begin
			hi = item.bit_high;
			lo = item.bit_low;
		end
	end

	assign hi5 = hi[4:0];
	assign lo5 = lo[4:0];

	// ones from lo up to hi inclusive
	assign mask = ({WORD_W{1'b1}} >> (5'(TOP_BIT) - hi5)) & ({WORD_W{1'b1}} << lo5);

	assign cmd.ok = ({1'b0, lo} >= 7'(ADDR_FIELD_BITS))
		&& (hi <= BIT_W'(TOP_BIT))
		&& ({1'b0, item.reg_index} < 4'(NUM_WORDS));
	assign cmd.idx  = item.reg_index;
	assign cmd.mask = mask;
	assign cmd.ins  = (item.field_value << lo5) & mask;

endmodule

`default_nettype wire

// File: design/shadow_register_dirty_flush.sv
//------------------------------------------------------------------------------
// shadow_register_dirty_flush
// Shadow word store with per-word dirty bits, field writes and word flushes.
//------------------------------------------------------------------------------
// The shadow words sit in a small RAM with one read and one write port. A field
// write that passes its checks has two steps: the word is read, then merged
// and written back (the dirty bit is set only if the word changed). A flush or
// write-all streams its n words out at one per cycle, highest index first, while
// the word port does not stall; the command port stays busy until the last word
// is loaded into the output register; the single RAM read port sets the pace.
// A flush with nothing dirty, an unused mode or a rejected field write leaves
// the port free on the next cycle. Words never written since reset read as
// their index, so no clearing pass is needed after reset.
`default_nettype none

module shadow_register_dirty_flush #(
	parameter int NUM_WORDS       = 7,
	parameter int ADDR_FIELD_BITS = 3
) (
	input  wire logic clk,
	input  wire logic arst_n,
	srdf_chan_if.sink   cmd,
	srdf_chan_if.source word
);

	import srdf_pkg::*;

	localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	in_item_t   item;
	field_cmd_t fcmd;

	logic                 cmd_acc;
	logic                 busy;
	logic [NUM_WORDS-1:0] dirty_q;
	logic [NUM_WORDS-1:0] send_q;
	logic [NUM_WORDS-1:0] valid_q;
	logic [AW-1:0]        sel;
	logic                 issue;
	logic                 out_load;
	logic                 re;
	logic [AW-1:0]        raddr;
	logic [WORD_W-1:0]    rdata;
	logic [WORD_W-1:0]    cur;
	logic [WORD_W-1:0]    nv;
	logic                 changed;
	logic                 we;

	logic                 emit_pend_s1;
	logic                 fw_s1;
	logic [AW-1:0]        idx_s1;
	logic                 rv_s1;
	logic                 last_s1;
	logic [WORD_W-1:0]    mask_s1;
	logic [WORD_W-1:0]    ins_s1;

	logic                 out_valid_q;
	out_item_t            out_q;

	assign item    = cmd.payload;
	assign busy    = (|send_q) || emit_pend_s1 || fw_s1;
	assign cmd.ready = !busy;
	assign cmd_acc = cmd.valid && !busy;

	srdf_field #(
		.NUM_WORDS       (NUM_WORDS),
		.ADDR_FIELD_BITS (ADDR_FIELD_BITS)
	) u_field (
		.item (item),
		.cmd  (fcmd)
	);

	// highest pending word goes first
	always_comb begin
		sel = '0;
		for (int k = 0; k < NUM_WORDS; k++) begin
			if (send_q[k]) begin
				sel = AW'(k);
			end
		end
	end

	assign out_load = emit_pend_s1 && (!out_valid_q || word.ready);
	assign issue    = (|send_q) && (!emit_pend_s1 || out_load);

	always_comb begin
		re    = 1'b0;
		raddr = sel;
		if (issue) begin
			re = 1'b1;
		end else if (cmd_acc && item.mode == MODE_FIELD && fcmd.ok) begin
			re    = 1'b1;
			raddr = fcmd.idx[AW-1:0];
		end
	end

	srdf_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx_s1),
		.wdata (nv),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// untouched words still hold their reset contents
	assign cur     = rv_s1 ? rdata : WORD_W'(idx_s1);
	assign nv      = (cur & ~mask_s1) | ins_s1;
	assign changed = nv != cur;
	assign we      = fw_s1 && changed;

	always_ff @(posedge clk) begin
		if (re) begin
			idx_s1  <= raddr;
			rv_s1   <= valid_q[raddr];
			last_s1 <= (send_q & ~(NUM_WORDS'(1) << sel)) == '0;
			mask_s1 <= fcmd.mask;
			ins_s1  <= fcmd.ins;
		end
		if (out_load) begin
			out_q.word_index <= IDX_W'(idx_s1);
			out_q.word_value <= cur;
			out_q.last_word  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q      <= '0;
			send_q       <= '0;
			valid_q      <= '0;
			emit_pend_s1 <= 1'b0;
			fw_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			fw_s1 <= cmd_acc && item.mode == MODE_FIELD && fcmd.ok;
			if (we) begin
				dirty_q[idx_s1] <= 1'b1;
				valid_q[idx_s1] <= 1'b1;
			end
			if (cmd_acc && item.mode == MODE_FLUSH) begin
				send_q  <= dirty_q | NUM_WORDS'(dirty_q[FORCE_WORD]);
				dirty_q <= '0;
			end else if (cmd_acc && item.mode == MODE_ALL) begin
				send_q  <= '1;
				dirty_q <= '0;
			end else if (issue) begin
				send_q[sel] <= 1'b0;
			end
			if (issue) begin
				emit_pend_s1 <= 1'b1;
			end else if (out_load) begin
				emit_pend_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (word.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign word.valid   = out_valid_q;
	assign word.payload = out_q;

endmodule

`default_nettype wire

// File: dv/testbench.sv
//------------------------------------------------------------------------------
// testbench
// Checks the shadow register file with dirty flush against an in-bench model.
// Field writes, flushes and write-alls go in over the command channel. Every
// word that comes out is compared with the oldest predicted word.
//------------------------------------------------------------------------------
`default_nettype none

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import srdf_pkg::*;

	localparam int NUM_WORDS       = 7;
	localparam int ADDR_FIELD_BITS = 3;
	localparam int RANDOM_CMDS     = 350;
	localparam int QUIET_TAIL      = 40;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int TAIL_CYCLES     = 20;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		in_item_t item;
		bit       drain;
	} pending_cmd_t;

	logic clk = 1'b0;
	logic arst_n;

	srdf_chan_if #(.payload_t(in_item_t))  cmd_if ();
	srdf_chan_if #(.payload_t(out_item_t)) word_if ();

	shadow_register_dirty_flush #(
		.NUM_WORDS      (NUM_WORDS),
		.ADDR_FIELD_BITS(ADDR_FIELD_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.word  (word_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model of the shadow words and their dirty bits
	logic [WORD_W-1:0]    shadow_copy [NUM_WORDS];
	logic [NUM_WORDS-1:0] dirty_copy;

	pending_cmd_t pending_cmds [$];
	out_item_t    expected_words [$];

	int cmds_issued = 0;
	int cmds_taken  = 0;
	int cmd_gap     = 0;
	int ready_gap   = 0;
	int errors      = 0;
	int cycle_count = 0;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic void reset_shadow();
		for (int k = 0; k < NUM_WORDS; k++) begin
			shadow_copy[k] = WORD_W'(k);
		end
		dirty_copy = '0;
	endfunction

	function automatic void queue_word(input int k, input bit last);
		out_item_t w;
		w.word_index = IDX_W'(k);
		w.word_value = shadow_copy[k];
		w.last_word  = last;
		expected_words.push_back(w);
	endfunction

	function automatic void merge_field(input in_item_t it);
		logic [BIT_W-1:0]  hi;
		logic [BIT_W-1:0]  lo;
		logic [BIT_W-1:0]  t;
		logic [63:0]       ones;
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] ins;
		logic [WORD_W-1:0] nv;
		int                width;
		hi = it.bit_high;
		lo = it.bit_low;
		if (lo > hi) begin
			t  = hi;
			hi = lo;
			lo = t;
		end
		if (lo < ADDR_FIELD_BITS || hi > TOP_BIT || it.reg_index >= NUM_WORDS) begin
			return;
		end
		width = int'(hi) - int'(lo) + 1;
		ones  = (64'd1 << width) - 64'd1;
		mask  = WORD_W'(ones << lo);
		ins   = WORD_W'(({32'd0, it.field_value} & ones) << lo);
		nv    = (shadow_copy[it.reg_index] & ~mask) | ins;
		if (nv != shadow_copy[it.reg_index]) begin
			shadow_copy[it.reg_index] = nv;
			dirty_copy[it.reg_index]  = 1'b1;
		end
	endfunction

	// updates the model and queues the words one command sends out
	function automatic void apply_command(input in_item_t it);
		logic [NUM_WORDS-1:0] send;
		case (it.mode)
			MODE_FIELD: begin
				merge_field(it);
			end
			MODE_FLUSH: begin
				send = dirty_copy;
				if (dirty_copy[FORCE_WORD]) begin
					send[0] = 1'b1;
				end
				for (int k = NUM_WORDS - 1; k >= 0; k--) begin
					if (send[k]) begin
						queue_word(k, (send & ((NUM_WORDS'(1) << k) - 1'b1)) == '0);
					end
				end
				dirty_copy = '0;
			end
			MODE_ALL: begin
				for (int k = NUM_WORDS - 1; k >= 0; k--) begin
					queue_word(k, k == 0);
				end
				dirty_copy = '0;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic push_cmd(input logic [MODE_W-1:0] mode, input int idx, input int hi,
			input int lo, input logic [WORD_W-1:0] value, input bit drain);
		pending_cmd_t p;
		p.item.mode        = mode;
		p.item.reg_index   = IDX_W'(idx);
		p.item.bit_high    = BIT_W'(hi);
		p.item.bit_low     = BIT_W'(lo);
		p.item.field_value = value;
		p.drain            = drain;
		pending_cmds.push_back(p);
	endtask

	task automatic build_directed();
		push_cmd(MODE_FLUSH, 0, 0, 0, '0, 1'b0);                 // nothing dirty yet
		push_cmd(MODE_ALL, 0, 0, 0, '0, 1'b0);                   // reset words
		push_cmd(MODE_UNUSED, 7, 63, 63, 32'hFFFF_FFFF, 1'b0);
		push_cmd(MODE_FIELD, 0, 31, 3, 32'hFFFF_FFFF, 1'b0);
		push_cmd(MODE_FIELD, 0, 31, 3, 32'hFFFF_FFFF, 1'b0);     // same value, word unchanged
		push_cmd(MODE_FIELD, 1, 3, 31, 32'h1234_5678, 1'b0);     // reversed bounds
		push_cmd(MODE_FIELD, 2, 10, 2, 32'hFFFF_FFFF, 1'b0);     // low bit too small
		push_cmd(MODE_FIELD, 3, 32, 5, 32'hFFFF_FFFF, 1'b0);     // high bit too big
		push_cmd(MODE_FIELD, 7, 20, 8, 32'hFFFF_FFFF, 1'b0);     // no such word
		push_cmd(MODE_FIELD, 5, 63, 0, 32'hFFFF_FFFF, 1'b0);
		push_cmd(MODE_FIELD, 2, 3, 3, 32'h0000_0001, 1'b0);
		push_cmd(MODE_FIELD, 3, 31, 31, 32'h0000_0001, 1'b0);
		push_cmd(MODE_FLUSH, 0, 0, 0, '0, 1'b1);
		push_cmd(MODE_FLUSH, 0, 0, 0, '0, 1'b0);
		push_cmd(MODE_FIELD, 4, 15, 8, 32'h0000_00A5, 1'b0);
		push_cmd(MODE_FLUSH, 0, 0, 0, '0, 1'b0);                 // word 4 drags word 0 along
		push_cmd(MODE_FIELD, 6, 31, 3, 32'h0000_0000, 1'b0);
		push_cmd(MODE_FIELD, 6, 31, 3, 32'hFFFF_FFFF, 1'b0);
		push_cmd(MODE_FIELD, 5, 7, 4, 32'h0000_000F, 1'b0);
		push_cmd(MODE_ALL, 0, 0, 0, '0, 1'b0);
		push_cmd(MODE_FLUSH, 0, 0, 0, '0, 1'b0);
		push_cmd(MODE_FIELD, 4, 31, 3, 32'h0000_0000, 1'b0);
		push_cmd(MODE_FLUSH, 0, 0, 0, '0, 1'b1);
	endtask

	task automatic build_random();
		int               r;
		int               hi;
		int               lo;
		int               t;
		logic [WORD_W-1:0] value;
		for (int i = 0; i < RANDOM_CMDS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				push_cmd(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 7),
					$urandom_range(0, 63), $urandom_range(0, 63), $urandom, 1'b0);
			end else if (r < 66) begin
				lo = $urandom_range(ADDR_FIELD_BITS, TOP_BIT);
				hi = $urandom_range(lo, TOP_BIT);
				if ($urandom_range(0, 2) == 0) begin
					t  = hi;
					hi = lo;
					lo = t;
				end
				case ($urandom_range(0, 7))
					0: value = '0;
					1: value = '1;
					default: value = $urandom;
				endcase
				push_cmd(MODE_FIELD, $urandom_range(0, NUM_WORDS - 1), hi, lo, value, 1'b0);
			end else if (r < 90) begin
				push_cmd(MODE_FLUSH, 0, 0, 0, $urandom, $urandom_range(0, 29) == 0);
			end else begin
				push_cmd(MODE_ALL, 0, 0, 0, $urandom, $urandom_range(0, 29) == 0);
			end
		end
	endtask

	// command driver, one transaction in flight at a time
	always @(negedge clk) begin : drive_cmd
		logic     next_valid;
		in_item_t next_item;
		if (arst_n) begin
			next_valid = cmd_if.valid;
			next_item  = cmd_if.payload;
			if (cmds_issued == cmds_taken) begin
				next_valid = 1'b0;
				if (cmd_gap > 0) begin
					cmd_gap--;
				end else if (pending_cmds.size() > 0 &&
						!(pending_cmds[0].drain && expected_words.size() != 0)) begin
					next_item  = pending_cmds[0].item;
					next_valid = 1'b1;
					pending_cmds.pop_front();
					cmds_issued++;
					if (pending_cmds.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0) begin
						cmd_gap = $urandom_range(1, 3);
					end
				end
			end
			cmd_if.valid   <= next_valid;
			cmd_if.payload <= next_item;
		end
	end

	// word sink with random stall bursts
	always @(negedge clk) begin : drive_ready
		if (arst_n) begin
			if (ready_gap > 0) begin
				ready_gap--;
				word_if.ready <= 1'b0;
			end else begin
				word_if.ready <= 1'b1;
				if (pending_cmds.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0) begin
					ready_gap = $urandom_range(1, 3);
				end
			end
		end
	end

	// output check first, then prediction for a command taken at the same edge
	always @(posedge clk) begin : check_words
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			if (word_if.valid && word_if.ready) begin
				got = word_if.payload;
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word idx=%0d value=%h last=%0d",
						got.word_index, got.word_value, got.last_word));
				end else begin
					want = expected_words.pop_front();
					if (got.word_index !== want.word_index || got.word_value !== want.word_value ||
							got.last_word !== want.last_word) begin
						report_mismatch($sformatf("got idx=%0d value=%h last=%0d, want idx=%0d value=%h last=%0d",
							got.word_index, got.word_value, got.last_word,
							want.word_index, want.word_value, want.last_word));
					end
				end
			end
			if (cmd_if.valid && cmd_if.ready) begin
				apply_command(cmd_if.payload);
				cmds_taken++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cmd_if.valid   = 1'b0;
		cmd_if.payload = '0;
		word_if.ready  = 1'b0;
		reset_shadow();
		build_directed();
		build_random();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		while (pending_cmds.size() != 0 || cmds_issued != cmds_taken ||
				expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
